@@ hdl/assert_macros.svh @@
// Assertion macros shared by the checking code of the design.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked assertion, ignored while reset is asserted.
`define SPMQ_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// Clocked assertion that is checked during reset as well.
`define SPMQ_ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk_i) (prop)) else $error(msg);

`endif

@@ hdl/spmq_pkg.sv @@
// Command and status codes of the strict priority multi-queue.
package spmq_pkg;

  typedef enum logic [1:0] {
    CMD_ENQUEUE = 2'd0,
    CMD_DEQUEUE = 2'd1,
    CMD_QUERY   = 2'd2,
    CMD_SPARE   = 2'd3
  } spmq_cmd_e;

  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_BAD_CLASS = 2'd1,
    ST_FULL      = 2'd2,
    ST_EMPTY     = 2'd3
  } spmq_status_e;

  localparam int unsigned CMD_W      = 2;
  localparam int unsigned CLASS_W    = 3;
  localparam int unsigned HANDLE_W   = 16;
  localparam int unsigned CCOUNT_W   = 7;
  localparam int unsigned TCOUNT_W   = 9;

endpackage

@@ hdl/strict_priority_multi_queue.sv @@
// Strict priority multi-queue: per-class FIFOs of handles in one shared RAM.
//
// Request channel: command_i, priority_class_i and payload_in_i with
// in_valid_i / in_stall_o. Result channel: status_o, payload_out_o,
// served_class_o, class_count_o and total_count_o with out_valid_o /
// out_stall_i. Every request yields exactly one result, in order.
// Enqueue writes the handle into the entry RAM at the class tail; dequeue
// picks the highest non-empty class with a priority encoder over the
// per-class counts, reads the head entry; query and spare only give counts.
// A result passes the RAM read stage and then the output register before
// it is valid. One request per cycle is sustained while out_stall_i is low,
// set by the single RAM port used once per request.
// Reset empties all queues at once (counts and pointers in flip-flops);
// the entry RAM is not cleared and needs no sweep.
// When the receiver stalls, the result holds in the output register,
// the next result waits in the RAM read stage, and in_stall_o rises
// only when both are occupied.
module strict_priority_multi_queue
  import spmq_pkg::*;
#(
  parameter int unsigned NUM_CLASSES   = 6,
  parameter int unsigned QUEUE_DEPTH   = 64,
  parameter int unsigned PAYLOAD_WIDTH = 16
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_stall_o,
  input  logic [CMD_W-1:0]    command_i,
  input  logic [CLASS_W-1:0]  priority_class_i,
  input  logic [HANDLE_W-1:0] payload_in_i,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output logic [1:0]          status_o,
  output logic [HANDLE_W-1:0] payload_out_o,
  output logic [CLASS_W-1:0]  served_class_o,
  output logic [CCOUNT_W-1:0] class_count_o,
  output logic [TCOUNT_W-1:0] total_count_o
);

`include "assert_macros.svh"

  localparam int unsigned CLS_W    = (NUM_CLASSES > 1) ? $clog2(NUM_CLASSES) : 1;
  localparam int unsigned PTR_W    = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int unsigned CNT_W    = $clog2(QUEUE_DEPTH + 1);
  localparam int unsigned RAM_D    = NUM_CLASSES * QUEUE_DEPTH;
  localparam int unsigned ADDR_W   = $clog2(RAM_D);
  localparam int unsigned TOT_W    = $clog2(RAM_D + 1);

  logic [PTR_W-1:0] head_q [NUM_CLASSES];
  logic [PTR_W-1:0] tail_q [NUM_CLASSES];
  logic [CNT_W-1:0] cnt_q  [NUM_CLASSES];
  logic [TOT_W-1:0] total_q, total_d;

  logic              accept;
  logic              s1_adv;
  logic              is_enq, is_deq;
  logic              cls_valid;
  logic [CLS_W-1:0]  req_cls, hit_cls, sel_cls;
  logic              hit_found;
  logic [CNT_W-1:0]  sel_cnt, new_cnt;
  logic [PTR_W-1:0]  sel_ptr, next_ptr;
  logic              enq_ok, deq_ok;
  spmq_status_e      res_status;
  logic [CCOUNT_W-1:0] res_ccnt;

  logic              ram_en;
  logic [ADDR_W-1:0] ram_addr;
  logic [PAYLOAD_WIDTH-1:0] ram_wdata, ram_rdata;

  logic                s1_vld_q;
  logic                s1_deq_q;
  spmq_status_e        s1_status_q;
  logic [CLASS_W-1:0]  s1_served_q;
  logic [CCOUNT_W-1:0] s1_ccnt_q;
  logic [TCOUNT_W-1:0] s1_total_q;

  logic                out_vld_q;
  spmq_status_e        out_status_q;
  logic [HANDLE_W-1:0] out_payload_q;
  logic [CLASS_W-1:0]  out_served_q;
  logic [CCOUNT_W-1:0] out_ccnt_q;
  logic [TCOUNT_W-1:0] out_total_q;

  assign s1_adv     = !out_vld_q || !out_stall_i;
  assign in_stall_o = s1_vld_q && !s1_adv;
  assign accept     = in_valid_i && !in_stall_o;

  assign is_enq    = command_i == CMD_ENQUEUE;
  assign is_deq    = command_i == CMD_DEQUEUE;
  assign cls_valid = 32'(priority_class_i) < NUM_CLASSES;
  assign req_cls   = CLS_W'(priority_class_i);

  always_comb begin
    hit_found = 1'b0;
    hit_cls   = '0;
    for (int c = 0; c < NUM_CLASSES; c++) begin
      if (cnt_q[c] != '0) begin
        hit_found = 1'b1;
        hit_cls   = CLS_W'(c);
      end
    end
  end

  assign sel_cls  = is_deq ? hit_cls : req_cls;
  assign sel_cnt  = cnt_q[sel_cls];
  assign sel_ptr  = is_enq ? tail_q[sel_cls] : head_q[sel_cls];
  assign next_ptr = (sel_ptr == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : sel_ptr + PTR_W'(1);
  assign enq_ok   = is_enq && cls_valid && (sel_cnt != CNT_W'(QUEUE_DEPTH));
  assign deq_ok   = is_deq && hit_found;

  always_comb begin
    priority if (enq_ok) begin
      new_cnt = sel_cnt + CNT_W'(1);
      total_d = total_q + TOT_W'(1);
    end else if (deq_ok) begin
      new_cnt = sel_cnt - CNT_W'(1);
      total_d = total_q - TOT_W'(1);
    end else begin
      new_cnt = sel_cnt;
      total_d = total_q;
    end
  end

  always_comb begin
    res_status = ST_OK;
    res_ccnt   = CCOUNT_W'(new_cnt);
    priority if (is_deq) begin
      if (!hit_found) begin
        res_status = ST_EMPTY;
        res_ccnt   = '0;
      end
    end else if (!cls_valid) begin
      res_status = ST_BAD_CLASS;
      res_ccnt   = '0;
    end else if (is_enq && !enq_ok) begin
      res_status = ST_FULL;
    end
  end

  assign ram_en    = accept && (enq_ok || deq_ok);
  assign ram_addr  = ADDR_W'(sel_cls) * ADDR_W'(QUEUE_DEPTH) + ADDR_W'(sel_ptr);
  assign ram_wdata = PAYLOAD_WIDTH'(payload_in_i);

  spmq_ram #(
    .WIDTH (PAYLOAD_WIDTH),
    .DEPTH (RAM_D)
  ) u_entry_ram (
    .clk_i   (clk_i),
    .en_i    (ram_en),
    .we_i    (enq_ok),
    .addr_i  (ram_addr),
    .wdata_i (ram_wdata),
    .rdata_o (ram_rdata)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int c = 0; c < NUM_CLASSES; c++) begin
        head_q[c] <= '0;
        tail_q[c] <= '0;
        cnt_q[c]  <= '0;
      end
      total_q   <= '0;
      s1_vld_q  <= 1'b0;
      out_vld_q <= 1'b0;
    end else begin
      if (accept) begin
        if (enq_ok) begin
          tail_q[sel_cls] <= next_ptr;
        end
        if (deq_ok) begin
          head_q[sel_cls] <= next_ptr;
        end
        if (enq_ok || deq_ok) begin
          cnt_q[sel_cls] <= new_cnt;
        end
        total_q <= total_d;
      end
      if (s1_adv || accept) begin
        s1_vld_q <= accept;
      end
      if (s1_adv) begin
        out_vld_q <= s1_vld_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      s1_deq_q    <= deq_ok;
      s1_status_q <= res_status;
      s1_served_q <= deq_ok ? CLASS_W'(hit_cls) : '0;
      s1_ccnt_q   <= res_ccnt;
      s1_total_q  <= TCOUNT_W'(total_d);
    end
    if (s1_adv && s1_vld_q) begin
      out_status_q  <= s1_status_q;
      out_payload_q <= s1_deq_q ? HANDLE_W'(ram_rdata) : '0;
      out_served_q  <= s1_served_q;
      out_ccnt_q    <= s1_ccnt_q;
      out_total_q   <= s1_total_q;
    end
  end

  assign out_valid_o    = out_vld_q;
  assign status_o       = out_status_q;
  assign payload_out_o  = out_payload_q;
  assign served_class_o = out_served_q;
  assign class_count_o  = out_ccnt_q;
  assign total_count_o  = out_total_q;

  `SPMQ_ASSERT(a_empty_counts, (out_vld_q && out_status_q == ST_EMPTY) |-> (out_total_q == '0 && out_ccnt_q == '0 && out_payload_q == '0), "empty result with nonzero counts")
  `SPMQ_ASSERT(a_full_count, (out_vld_q && out_status_q == ST_FULL) |-> (out_ccnt_q == CCOUNT_W'(QUEUE_DEPTH)), "full result without full count")
  `SPMQ_ASSERT_ALWAYS(a_stall_needs_both, in_stall_o |-> (s1_vld_q && out_vld_q), "input stalled with a free stage")

endmodule

@@ hdl/spmq_ram.sv @@
// Generic single-port RAM with registered read data.
module spmq_ram #(
  parameter int unsigned WIDTH = 16,
  parameter int unsigned DEPTH = 384
) (
  input  logic                     clk_i,
  input  logic                     en_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] addr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      if (we_i) begin
        mem_q[addr_i] <= wdata_i;
      end else begin
        rdata_q <= mem_q[addr_i];
      end
    end
  end

  assign rdata_o = rdata_q;

endmodule

@@ test/strict_priority_multi_queue_checker.sv @@
// Result checker for the strict priority multi-queue: tracks the class queues, compares each result.
`timescale 1ns / 1ps

module strict_priority_multi_queue_checker
  import spmq_pkg::*;
#(
  parameter int unsigned NUM_CLASSES   = 6,
  parameter int unsigned QUEUE_DEPTH   = 64,
  parameter int unsigned PAYLOAD_WIDTH = 16
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  input  logic                in_stall_o,
  input  logic [CMD_W-1:0]    command_i,
  input  logic [CLASS_W-1:0]  priority_class_i,
  input  logic [HANDLE_W-1:0] payload_in_i,
  input  logic                out_valid_o,
  input  logic                out_stall_i,
  input  logic [1:0]          status_o,
  input  logic [HANDLE_W-1:0] payload_out_o,
  input  logic [CLASS_W-1:0]  served_class_o,
  input  logic [CCOUNT_W-1:0] class_count_o,
  input  logic [TCOUNT_W-1:0] total_count_o,
  output int                  fail_count_o,
  output int                  pending_o
);

  typedef struct packed {
    spmq_status_e          status;
    logic [HANDLE_W-1:0]   handle;
    logic [CLASS_W-1:0]    served;
    logic [CCOUNT_W-1:0]   ccount;
    logic [TCOUNT_W-1:0]   tcount;
  } queue_result_t;

  localparam logic [HANDLE_W-1:0] HANDLE_MASK = {HANDLE_W{1'b1}} >> (HANDLE_W - PAYLOAD_WIDTH);

  logic [HANDLE_W-1:0] class_fifo [NUM_CLASSES][$];
  queue_result_t       awaited_results [$];
  queue_result_t       want;
  queue_result_t       seen;
  int                  mismatch_count = 0;
  int                  awaited_count  = 0;

  assign fail_count_o = mismatch_count;
  assign pending_o    = awaited_count;

  function automatic queue_result_t serve_request(spmq_cmd_e cmd, logic [CLASS_W-1:0] cls,
                                                  logic [HANDLE_W-1:0] handle);
    queue_result_t r;
    int            top_class;
    int            total;
    r         = '0;
    r.status  = ST_OK;
    top_class = -1;
    total     = 0;
    case (cmd)
      CMD_ENQUEUE: begin
        if (cls >= NUM_CLASSES) begin
          r.status = ST_BAD_CLASS;
        end else if (class_fifo[cls].size() >= QUEUE_DEPTH) begin
          r.status = ST_FULL;
          r.ccount = CCOUNT_W'(class_fifo[cls].size());
        end else begin
          class_fifo[cls].push_back(handle & HANDLE_MASK);
          r.ccount = CCOUNT_W'(class_fifo[cls].size());
        end
      end
      CMD_DEQUEUE: begin
        for (int c = NUM_CLASSES - 1; c >= 0; c--) begin
          if (top_class < 0 && class_fifo[c].size() != 0) top_class = c;
        end
        if (top_class < 0) begin
          r.status = ST_EMPTY;
        end else begin
          r.handle = class_fifo[top_class].pop_front();
          r.served = CLASS_W'(top_class);
          r.ccount = CCOUNT_W'(class_fifo[top_class].size());
        end
      end
      default: begin
        if (cls >= NUM_CLASSES) r.status = ST_BAD_CLASS;
        else r.ccount = CCOUNT_W'(class_fifo[cls].size());
      end
    endcase
    for (int c = 0; c < NUM_CLASSES; c++) total += class_fifo[c].size();
    r.tcount = TCOUNT_W'(total);
    return r;
  endfunction

  function automatic int count_mismatches(queue_result_t exp_r, queue_result_t got_r);
    int bad;
    bad = 0;
    if (got_r.status !== exp_r.status) begin
      $error("status: expected %0d, got %0d", exp_r.status, got_r.status);
      bad++;
    end
    if (got_r.handle !== exp_r.handle) begin
      $error("payload_out: expected %0d, got %0d", exp_r.handle, got_r.handle);
      bad++;
    end
    if (got_r.served !== exp_r.served) begin
      $error("served_class: expected %0d, got %0d", exp_r.served, got_r.served);
      bad++;
    end
    if (got_r.ccount !== exp_r.ccount) begin
      $error("class_count: expected %0d, got %0d", exp_r.ccount, got_r.ccount);
      bad++;
    end
    if (got_r.tcount !== exp_r.tcount) begin
      $error("total_count: expected %0d, got %0d", exp_r.tcount, got_r.tcount);
      bad++;
    end
    return bad;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int c = 0; c < NUM_CLASSES; c++) class_fifo[c].delete();
      awaited_results.delete();
      awaited_count = 0;
    end else begin
      if (in_valid_i && !in_stall_o) begin
        awaited_results.push_back(serve_request(spmq_cmd_e'(command_i), priority_class_i,
                                                payload_in_i));
      end
      if (out_valid_o && !out_stall_i) begin
        seen = '{status: spmq_status_e'(status_o), handle: payload_out_o,
                 served: served_class_o, ccount: class_count_o, tcount: total_count_o};
        if (awaited_results.size() == 0) begin
          $error("result with no request outstanding: status %0d, payload_out %0d",
                 status_o, payload_out_o);
          mismatch_count++;
        end else begin
          want = awaited_results.pop_front();
          mismatch_count += count_mismatches(want, seen);
        end
      end
      awaited_count = awaited_results.size();
    end
  end

endmodule

@@ test/strict_priority_multi_queue_test.sv @@
// Testbench top for the strict priority multi-queue: clock, reset, request traffic and verdict.
`timescale 1ns / 1ps

module strict_priority_multi_queue_test;
  import spmq_pkg::*;

  localparam int unsigned NUM_CLASSES   = 6;
  localparam int unsigned QUEUE_DEPTH   = 64;
  localparam int unsigned PAYLOAD_WIDTH = 16;
  localparam int          HOLD_CYCLES   = 300;
  localparam int          DRAIN_CYCLES  = 10;

  typedef enum int {
    MODE_FILL,
    MODE_DRAIN,
    MODE_MIX
  } traffic_mode_e;

  logic                clk_i;
  logic                rst_ni           = 1'b0;
  logic                in_valid_i       = 1'b0;
  logic                in_stall_o;
  logic [CMD_W-1:0]    command_i        = '0;
  logic [CLASS_W-1:0]  priority_class_i = '0;
  logic [HANDLE_W-1:0] payload_in_i     = '0;
  logic                out_valid_o;
  logic                out_stall_i      = 1'b0;
  logic [1:0]          status_o;
  logic [HANDLE_W-1:0] payload_out_o;
  logic [CLASS_W-1:0]  served_class_o;
  logic [CCOUNT_W-1:0] class_count_o;
  logic [TCOUNT_W-1:0] total_count_o;

  int fail_count;
  int pending;
  int send_idle_pct   = 0;
  int stall_pct       = 0;
  bit hold_off_req    = 1'b0;
  bit hold_done       = 1'b0;
  int hold_left       = 0;

  strict_priority_multi_queue #(
    .NUM_CLASSES  (NUM_CLASSES),
    .QUEUE_DEPTH  (QUEUE_DEPTH),
    .PAYLOAD_WIDTH(PAYLOAD_WIDTH)
  ) i_dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .in_valid_i      (in_valid_i),
    .in_stall_o      (in_stall_o),
    .command_i       (command_i),
    .priority_class_i(priority_class_i),
    .payload_in_i    (payload_in_i),
    .out_valid_o     (out_valid_o),
    .out_stall_i     (out_stall_i),
    .status_o        (status_o),
    .payload_out_o   (payload_out_o),
    .served_class_o  (served_class_o),
    .class_count_o   (class_count_o),
    .total_count_o   (total_count_o)
  );

  strict_priority_multi_queue_checker #(
    .NUM_CLASSES  (NUM_CLASSES),
    .QUEUE_DEPTH  (QUEUE_DEPTH),
    .PAYLOAD_WIDTH(PAYLOAD_WIDTH)
  ) i_checker (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .in_valid_i      (in_valid_i),
    .in_stall_o      (in_stall_o),
    .command_i       (command_i),
    .priority_class_i(priority_class_i),
    .payload_in_i    (payload_in_i),
    .out_valid_o     (out_valid_o),
    .out_stall_i     (out_stall_i),
    .status_o        (status_o),
    .payload_out_o   (payload_out_o),
    .served_class_o  (served_class_o),
    .class_count_o   (class_count_o),
    .total_count_o   (total_count_o),
    .fail_count_o    (fail_count),
    .pending_o       (pending)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  initial begin
    #2_000_000;
    $display("strict_priority_multi_queue_test: done, errors");
    $finish;
  end

  always @(posedge clk_i) begin
    if (hold_off_req && !hold_done) begin
      hold_left = HOLD_CYCLES;
      hold_done = 1'b1;
    end
    if (hold_left > 0) begin
      hold_left--;
      out_stall_i <= 1'b1;
    end else begin
      out_stall_i <= ($urandom_range(99) < stall_pct);
    end
  end

  task automatic send_request(spmq_cmd_e cmd, logic [CLASS_W-1:0] cls,
                              logic [HANDLE_W-1:0] handle);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i       <= 1'b1;
    command_i        <= cmd;
    priority_class_i <= cls;
    payload_in_i     <= handle;
    do @(posedge clk_i); while (in_stall_o);
  endtask

  task automatic send_random(int count, bit open_with_fill);
    traffic_mode_e       mode;
    int                  seg_left;
    int                  focus;
    int                  r;
    spmq_cmd_e           cmd;
    logic [CLASS_W-1:0]  cls;
    mode     = MODE_FILL;
    seg_left = open_with_fill ? 90 : 0;
    focus    = $urandom_range(0, NUM_CLASSES - 1);
    for (int n = 0; n < count; n++) begin
      if (seg_left == 0) begin
        r        = $urandom_range(99);
        mode     = (r < 30) ? MODE_FILL : (r < 70) ? MODE_DRAIN : MODE_MIX;
        seg_left = $urandom_range(20, 100);
        focus    = $urandom_range(0, NUM_CLASSES - 1);
      end
      seg_left--;
      r   = $urandom_range(99);
      cls = ($urandom_range(99) < 8) ? CLASS_W'($urandom_range(NUM_CLASSES, 7))
                                     : CLASS_W'($urandom_range(0, NUM_CLASSES - 1));
      case (mode)
        MODE_FILL: begin
          cmd = (r < 88) ? CMD_ENQUEUE : spmq_cmd_e'($urandom_range(1, 3));
          if ($urandom_range(99) < 85) cls = CLASS_W'(focus);
        end
        MODE_DRAIN: cmd = (r < 80) ? CMD_DEQUEUE : CMD_ENQUEUE;
        default: begin
          cmd = (r < 40) ? CMD_ENQUEUE : (r < 75) ? CMD_DEQUEUE :
                (r < 90) ? CMD_QUERY : CMD_SPARE;
        end
      endcase
      send_request(cmd, cls, HANDLE_W'($urandom_range(0, 65535)));
    end
  endtask

  initial begin
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    send_request(CMD_DEQUEUE, 3'd0, 16'h0000);
    send_request(CMD_QUERY, 3'd0, 16'h0000);
    send_request(CMD_QUERY, 3'd6, 16'h0000);
    send_request(CMD_QUERY, 3'd7, 16'hFFFF);
    send_request(CMD_SPARE, 3'd5, 16'hFFFF);
    send_request(CMD_SPARE, 3'd7, 16'h0000);
    send_request(CMD_ENQUEUE, 3'd6, 16'h5A5A);
    send_request(CMD_ENQUEUE, 3'd7, 16'hFFFF);
    send_request(CMD_ENQUEUE, 3'd0, 16'h0000);
    send_request(CMD_ENQUEUE, 3'd0, 16'hFFFF);
    send_request(CMD_ENQUEUE, 3'd2, 16'h1234);
    send_request(CMD_ENQUEUE, 3'd5, 16'h8001);
    send_request(CMD_ENQUEUE, 3'd5, 16'h7FFE);
    send_request(CMD_QUERY, 3'd5, 16'h0000);
    send_request(CMD_SPARE, 3'd0, 16'h0000);
    send_request(CMD_DEQUEUE, 3'd7, 16'h0000);
    send_request(CMD_DEQUEUE, 3'd0, 16'h0000);
    send_request(CMD_DEQUEUE, 3'd0, 16'h0000);
    send_request(CMD_DEQUEUE, 3'd0, 16'h0000);
    send_request(CMD_DEQUEUE, 3'd0, 16'h0000);
    send_request(CMD_DEQUEUE, 3'd0, 16'h0000);
    send_request(CMD_QUERY, 3'd2, 16'h0000);

    hold_off_req <= 1'b1;
    send_random(270, 1'b1);

    send_idle_pct = 56;
    send_random(270, 1'b0);

    send_idle_pct = 0;
    stall_pct <= 56;
    send_random(270, 1'b0);

    send_idle_pct = 22;
    stall_pct <= 22;
    send_random(270, 1'b0);

    send_idle_pct = 0;
    stall_pct <= 0;
    send_random(60, 1'b0);

    in_valid_i <= 1'b0;
    do @(posedge clk_i); while (pending != 0);
    repeat (DRAIN_CYCLES) @(posedge clk_i);

    if (fail_count == 0 && pending == 0) begin
      $display("strict_priority_multi_queue_test: done, clean");
    end else begin
      $display("strict_priority_multi_queue_test: done, errors");
    end
    $finish;
  end

endmodule
